### rtl/rsd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the Rice stream decoder.
// ---------------------------------------------------------------------------
package rsd_pkg;

  localparam int COUNT_WIDTH    = 16;
  localparam int WORD_BITS      = 32;
  localparam int BIT_CNT_W      = $clog2(WORD_BITS);
  localparam int PARAM_W        = 5;
  localparam int PARAM_MAX      = 31;
  localparam int SEEN_W         = 17;
  localparam int USED_W         = 18;
  localparam int WORDS_SEEN_MAX = 131071;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_REMAINDER,
    PH_UNARY
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 eos;
    logic [USED_W-1:0]    words;
  } res_t;

endpackage

`default_nettype wire

### rtl/rice_stream_decoder_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rice_stream_decoder_top
// Rice/Golomb stream decoder: one coded bit per cycle, bar output stalls, through a shared
// remainder/unary accumulator, one result held back to tag end_of_word.
// ---------------------------------------------------------------------------
// Header word: taken while idle, no result.
// Data word: accepted while idle, then decoded bit by bit in ST_BITS and, if a result is
//   held, ST_FLUSH presents it with end_of_word; the bit steps end early when the
//   stream ends. in_stall is high through the bit and flush cycles.
// Output stalls hold the decoder while a second result waits for the output reg.
// rst (sync, active high) clears the sequencer and decoder state and sets the stored value count to 1.
module rice_stream_decoder_top
  import rsd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [COUNT_WIDTH-1:0] value_count,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [WORD_BITS-1:0]   stream_word,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [WORD_BITS-1:0]        value,
  output logic                        end_of_word,
  output logic                        end_of_stream,
  output logic [USED_W-1:0]           words_used
);

  state_t                 state, state_next;
  phase_t                 phase, phase_next;
  logic [PARAM_W-1:0]     rice_param, rice_param_next;
  logic [PARAM_W-1:0]     rbits, rbits_next;
  logic [WORD_BITS-1:0]   partial, partial_next;
  logic [COUNT_WIDTH-1:0] values_done, values_done_next;
  logic [SEEN_W-1:0]      words_seen, words_seen_next;
  logic [COUNT_WIDTH-1:0] count_reg;
  logic [WORD_BITS-1:0]   word_sr, word_sr_next;
  logic [BIT_CNT_W-1:0]   bit_cnt, bit_cnt_next;
  res_t                   pend, pend_next;
  logic                   pend_valid, pend_valid_next;
  logic                   out_valid_next;
  logic                   load_out;
  res_t                   out_res;
  logic                   out_eow;

  logic                   bit_in;
  logic                   out_free;
  logic                   adv;
  logic                   produce;
  logic                   last_val;
  logic                   word_end;
  logic [COUNT_WIDTH-1:0] vd_inc;
  logic [COUNT_WIDTH-1:0] limit;
  logic [PARAM_W:0]       rbits_inc;
  logic [PARAM_W-1:0]     hdr_param;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_HEADER;
      rice_param  <= '0;
      rbits       <= '0;
      partial     <= '0;
      values_done <= '0;
      words_seen  <= '0;
      count_reg   <= COUNT_WIDTH'(1);
      bit_cnt     <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      rice_param  <= rice_param_next;
      rbits       <= rbits_next;
      partial     <= partial_next;
      values_done <= values_done_next;
      words_seen  <= words_seen_next;
      bit_cnt     <= bit_cnt_next;
      pend_valid  <= pend_valid_next;
      out_valid   <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        count_reg <= value_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_sr <= word_sr_next;
    pend    <= pend_next;
    if (load_out) begin
      value         <= out_res.value;
      end_of_stream <= out_res.eos;
      words_used    <= out_res.words;
      end_of_word   <= out_eow;
    end
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    rice_param_next  = rice_param;
    rbits_next       = rbits;
    partial_next     = partial;
    values_done_next = values_done;
    words_seen_next  = words_seen;
    word_sr_next     = word_sr;
    bit_cnt_next     = bit_cnt;
    pend_next        = pend;
    pend_valid_next  = pend_valid;
    load_out         = 1'b0;
    out_res          = pend;
    out_eow          = 1'b0;

    bit_in    = word_sr[0];
    out_free  = !out_valid || !out_stall;
    produce   = (state == ST_BITS) && (phase == PH_UNARY) && !bit_in;
    adv       = (state == ST_BITS) && !(produce && pend_valid && !out_free);
    vd_inc    = values_done + COUNT_WIDTH'(1);
    limit     = (count_reg == '0) ? COUNT_WIDTH'(1) : count_reg;
    last_val  = (vd_inc >= limit) || (vd_inc == '0);
    word_end  = (bit_cnt == BIT_CNT_W'(WORD_BITS - 1));
    rbits_inc = {1'b0, rbits} + (PARAM_W + 1)'(1);
    hdr_param = (stream_word > WORD_BITS'(PARAM_MAX)) ? PARAM_W'(PARAM_MAX)
                                                        : stream_word[PARAM_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (phase == PH_HEADER) begin
            rice_param_next  = hdr_param;
            values_done_next = '0;
            words_seen_next  = SEEN_W'(1);
            partial_next     = '0;
            rbits_next       = '0;
            phase_next       = (hdr_param == '0) ? PH_UNARY : PH_REMAINDER;
          end else begin
            if (words_seen != SEEN_W'(WORDS_SEEN_MAX)) begin
              words_seen_next = words_seen + SEEN_W'(1);
            end
            word_sr_next = stream_word;
            bit_cnt_next = '0;
            state_next   = ST_BITS;
          end
        end
      end
      ST_BITS: begin
        if (adv) begin
          word_sr_next = word_sr >> 1;
          bit_cnt_next = bit_cnt + BIT_CNT_W'(1);
          if (phase == PH_REMAINDER) begin
            partial_next = partial | (WORD_BITS'(bit_in) << rbits);
            rbits_next   = rbits_inc[PARAM_W-1:0];
            if (rbits_inc >= {1'b0, rice_param}) begin
              phase_next = PH_UNARY;
            end
          end else if (bit_in) begin
            partial_next = partial + (WORD_BITS'(1) << rice_param);
          end else begin
            values_done_next = vd_inc;
            if (pend_valid) begin
              load_out = 1'b1;
              out_res  = pend;
              out_eow  = 1'b0;
            end
            pend_next.value = partial;
            pend_next.eos   = last_val;
            pend_next.words = last_val ? {1'b0, words_seen} : '0;
            pend_valid_next = 1'b1;
            partial_next    = '0;
            rbits_next      = '0;
            if (last_val) begin
              phase_next      = PH_HEADER;
              rice_param_next = '0;
            end else begin
              phase_next = (rice_param == '0) ? PH_UNARY : PH_REMAINDER;
            end
          end
          if ((produce && last_val) || word_end) begin
            state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          load_out        = 1'b1;
          out_res         = pend;
          out_eow         = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_eos_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_stream |-> (words_used != '0) && end_of_word)
    else $error("end of stream without word count or end of word");

  a_words_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_stream |-> (words_used == '0))
    else $error("word count on a non-final result");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held result left behind when idle");

  a_flush_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) && (state_next == ST_IDLE) |=> out_valid && end_of_word)
    else $error("flush did not present end of word");
`endif

endmodule

`default_nettype wire
